// ===== rtl/battery_voltage_average_ema_assert.svh =====
// Assertion macros for the battery voltage averaging block.
// The macros expect signals named clk and arst_n in the scope where they are used.
// With SYNTHESIS defined, every macro expands to nothing.
`ifndef BATTERY_VOLTAGE_AVERAGE_EMA_ASSERT_SVH
`define BATTERY_VOLTAGE_AVERAGE_EMA_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define BVAE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bvae assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define BVAE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bvae assertion failed");
`else
`define BVAE_ASSERT_NOW(lbl, ante, cons)
`define BVAE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/bvae_pkg.sv =====
// Shared constants, register types and configuration codes for the battery voltage averager.
// It depends on nothing. Every other file of the block but the assertion header imports it.
`timescale 1ns / 1ps

package bvae_pkg;

	// Block length and effective converter resolution.
	localparam int SAMPLE_COUNT = 8;
	localparam int ADC_BITS     = 12;

	// Field and state widths.
	localparam int SAMPLE_W  = 12;
	localparam int MASK_W    = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
	localparam int SUM_W     = 18;
	localparam int IDX_W     = 6;
	localparam int MV_W      = 24;
	localparam int ALPHA_W   = 16;
	localparam int Q_W       = 32;
	localparam int MV_OUT_W  = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Division of the block sum by SAMPLE_COUNT as a multiply by a rounded-up reciprocal.
	// With a sum below 2^18 and a count up to 64, a 24-bit shift gives the exact quotient.
	localparam int DIV_SHIFT = SUM_W + IDX_W;
	localparam logic [MUL_B_W-1:0] DIV_RECIP =
		MUL_B_W'(((64'd1 << DIV_SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);

	// Sample counter value that closes a block.
	localparam logic [IDX_W-1:0] END_IDX = IDX_W'(SAMPLE_COUNT % (1 << IDX_W));

	// Register reset values.
	localparam logic [MV_W-1:0]    MV_RESET    = 24'd580000;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MV_PER_COUNT = 1'd0,
		CFG_FILTER_ALPHA = 1'd1
	} cfg_idx_t;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [MV_W-1:0]    mv_per_count;
		logic [ALPHA_W-1:0] alpha;
	} cfg_regs_t;

endpackage

// ===== rtl/bvae_cfg.sv =====
// Configuration register file of the battery voltage averager.
// It depends on bvae_pkg for the register indexes, widths and reset values.
`timescale 1ns / 1ps

module bvae_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bvae_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bvae_pkg::CFG_DATA_W-1:0]  cfg_data,
	output bvae_pkg::cfg_regs_t              regs
);
	import bvae_pkg::*;

	cfg_regs_t regs_q;

	// A write never stalls, so the port is always ready.
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Decode the index and update the addressed register on each beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mv_per_count <= MV_RESET;
			regs_q.alpha        <= ALPHA_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MV_PER_COUNT: regs_q.mv_per_count <= cfg_data[MV_W-1:0];
				CFG_FILTER_ALPHA: regs_q.alpha        <= cfg_data[ALPHA_W-1:0];
			endcase
		end
	end

endmodule

// ===== rtl/bvae_mul.sv =====
// Shared unsigned multiplier with a registered product.
// It depends on bvae_pkg for the operand and product widths.
`timescale 1ns / 1ps

module bvae_mul (
	input  logic                           clk,
	input  logic [bvae_pkg::MUL_A_W-1:0]   mul_a,
	input  logic [bvae_pkg::MUL_B_W-1:0]   mul_b,
	output logic [bvae_pkg::MUL_P_W-1:0]   prod
);
	import bvae_pkg::*;

	logic [MUL_P_W-1:0] prod_q;

	// The product is registered and available in the cycle after the operands are presented.
	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	end

	assign prod = prod_q;

endmodule

// ===== rtl/battery_voltage_average_ema.sv =====
// Battery voltage averager: each input beat is one ADC conversion. A mid-block sample gives
// no result. A failed conversion gives one result. The beat that closes a block of
// SAMPLE_COUNT samples starts a sequence of steps, because one registered multiplier is used
// in turn for the division by the block length, the scaling to millivolts and the filter
// step; the input is not ready while that sequence runs. The sequence waits in its last
// step while the output register is busy, until the previous result is taken. A finished
// result sits in an output register, so the next sample may be taken while it waits.
// Depends on bvae_pkg, bvae_cfg, bvae_mul and battery_voltage_average_ema_assert.svh.
`timescale 1ns / 1ps
`include "battery_voltage_average_ema_assert.svh"

module battery_voltage_average_ema (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bvae_pkg::SAMPLE_W-1:0]    adc_sample,
	input  logic                             conv_error,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bvae_pkg::SAMPLE_W-1:0]    adc_average,
	output logic [bvae_pkg::MV_OUT_W-1:0]    voltage_raw_mv,
	output logic [bvae_pkg::MV_OUT_W-1:0]    voltage_filtered_mv,
	output logic                             reading_valid,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bvae_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bvae_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bvae_pkg::*;

	localparam int STEP_W = Q_W + ALPHA_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_AVG,
		ST_SAT,
		ST_DIFF,
		ST_MULF,
		ST_UPD,
		ST_DONE
	} state_t;

	state_t               state_q;
	cfg_regs_t            regs;
	logic [SUM_W-1:0]     sum_q;
	logic [IDX_W-1:0]     idx_q;
	logic [Q_W-1:0]       filt_q;
	logic                 filt_loaded_q;
	logic [SAMPLE_W-1:0]  avg_q;
	logic [Q_W-1:0]       volt_q;
	logic [Q_W-1:0]       diff_q;
	logic                 up_q;
	logic                 res_ok_q;
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  out_avg_q;
	logic [MV_OUT_W-1:0]  out_raw_q;
	logic [MV_OUT_W-1:0]  out_filt_q;
	logic                 out_ok_q;

	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [MUL_P_W-1:0]   prod;

	logic [SUM_W-1:0]     sum_next;
	logic [IDX_W-1:0]     idx_next;
	logic [SAMPLE_W-1:0]  avg;
	logic [Q_W-1:0]       volt_sat;
	logic [Q_W-1:0]       step_up;
	logic [STEP_W-1:0]    step_rnd;
	logic [Q_W-1:0]       step_dn;
	logic                 out_free;

	// Configuration registers.
	bvae_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// Shared multiplier.
	bvae_mul u_mul (
		.clk   (clk),
		.mul_a (mul_a),
		.mul_b (mul_b),
		.prod  (prod)
	);

	// Operand selection for the multiplier in each step of the sequence.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_DIV: begin
				mul_a = MUL_A_W'(sum_q);
				mul_b = DIV_RECIP;
			end
			ST_AVG: begin
				mul_a = MUL_A_W'(avg);
				mul_b = MUL_B_W'(regs.mv_per_count);
			end
			ST_MULF: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'(regs.alpha);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Accumulation, quotient, saturation and filter step values.
	always_comb begin
		sum_next = sum_q + SUM_W'(adc_sample[MASK_W-1:0]);
		idx_next = idx_q + IDX_W'(1);
		avg      = prod[DIV_SHIFT +: SAMPLE_W];
		volt_sat = (|prod[MUL_P_W-1:Q_W]) ? '1 : prod[Q_W-1:0];
		step_up  = prod[ALPHA_W +: Q_W];
		step_rnd = prod[STEP_W-1:0] + STEP_W'({ALPHA_W{1'b1}});
		step_dn  = step_rnd[ALPHA_W +: Q_W];
	end

	assign out_free = !out_valid_q || out_ready;

	// Sequencer with the block state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sum_q         <= '0;
			idx_q         <= '0;
			filt_q        <= '0;
			filt_loaded_q <= 1'b0;
			avg_q         <= '0;
			volt_q        <= '0;
			diff_q        <= '0;
			up_q          <= 1'b0;
			res_ok_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			out_avg_q     <= '0;
			out_raw_q     <= '0;
			out_filt_q    <= '0;
			out_ok_q      <= 1'b0;
		end else begin
			// The result step reloads the output register itself when it is taken.
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (conv_error) begin
							// A failed conversion drops the block and reports an invalid reading.
							sum_q    <= '0;
							idx_q    <= '0;
							avg_q    <= '0;
							volt_q   <= '0;
							res_ok_q <= 1'b0;
							state_q  <= ST_DONE;
						end else if (idx_next == END_IDX) begin
							sum_q   <= sum_next;
							idx_q   <= '0;
							state_q <= ST_DIV;
						end else begin
							sum_q <= sum_next;
							idx_q <= idx_next;
						end
					end
				end
				ST_DIV: begin
					// The quotient multiply is under way; the running sum restarts.
					sum_q   <= '0;
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					avg_q <= avg;
					if (avg == '0) begin
						volt_q   <= '0;
						res_ok_q <= 1'b0;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					volt_q <= volt_sat;
					if (!filt_loaded_q) begin
						// The first valid block loads the filter directly.
						filt_q        <= volt_sat;
						filt_loaded_q <= 1'b1;
						res_ok_q      <= 1'b1;
						state_q       <= ST_DONE;
					end else begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					up_q    <= (volt_q >= filt_q);
					diff_q  <= (volt_q >= filt_q) ? (volt_q - filt_q) : (filt_q - volt_q);
					state_q <= ST_MULF;
				end
				ST_MULF: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					// Both directions round toward minus infinity.
					filt_q   <= up_q ? (filt_q + step_up) : (filt_q - step_dn);
					res_ok_q <= 1'b1;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_avg_q   <= avg_q;
						out_raw_q   <= volt_q[Q_W-1 -: MV_OUT_W];
						out_filt_q  <= filt_q[Q_W-1 -: MV_OUT_W];
						out_ok_q    <= res_ok_q;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign in_ready            = (state_q == ST_IDLE);
	assign out_valid           = out_valid_q;
	assign adc_average         = out_avg_q;
	assign voltage_raw_mv      = out_raw_q;
	assign voltage_filtered_mv = out_filt_q;
	assign reading_valid       = out_ok_q;

	// A valid reading always carries a nonzero average.
	`BVAE_ASSERT_NOW(a_valid_nonzero, out_valid && reading_valid, adc_average != '0)
	// An invalid reading carries zero average and zero raw voltage.
	`BVAE_ASSERT_NOW(a_invalid_zero, out_valid && !reading_valid, adc_average == '0 && voltage_raw_mv == '0)
	// Once the filter is loaded it stays loaded.
	`BVAE_ASSERT_NEXT(a_loaded_sticky, filt_loaded_q, filt_loaded_q)
	// A failed conversion goes straight to the result step.
	`BVAE_ASSERT_NEXT(a_error_done, in_valid && in_ready && conv_error, state_q == ST_DONE)

endmodule
